FILE: sv/hgc_pkg.sv
// hgc_pkg: shared widths, register codes, struct types and the tetrahedron
// split tables for the hex-to-tet grid connectivity block. No dependencies.
`default_nettype none

package hgc_pkg;

  localparam int unsigned MAX_CELLS_DEFAULT = 64;
  localparam int unsigned TETS_PER_CELL     = 12;
  localparam int unsigned CNT_W             = $clog2(TETS_PER_CELL);
  localparam int unsigned IDX_W             = 20;
  localparam int unsigned COORD_W           = 6;
  localparam int unsigned CFG_W             = 7;
  localparam int unsigned CFG_IDX_W         = 2;

  localparam logic [CNT_W-1:0] LAST_TET = CNT_W'(TETS_PER_CELL - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELLS_X = 2'd0,
    REG_CELLS_Y = 2'd1,
    REG_CELLS_Z = 2'd2
  } cfg_reg_e;

  // Clamped cell counts per axis.
  typedef struct packed {
    logic [CFG_W-1:0] cx;
    logic [CFG_W-1:0] cy;
    logic [CFG_W-1:0] cz;
  } grid_t;

  // Per-cell geometry handed to the emitter.
  typedef struct packed {
    logic [IDX_W-1:0] base;   // index of local corner 0
    logic [IDX_W-1:0] apex;   // centre vertex
    logic [IDX_W-1:0] plane;  // x stride, (cy+1)*(cz+1)
    logic [CFG_W:0]   nz;     // y stride, cz+1
    logic             odd;    // diagonal pattern select
    logic             bad;    // cell outside grid
  } geom_t;

  // Three local corners {a,b,c} of tetrahedron t; corner = (dx<<2)|(dy<<1)|dz.
  function automatic logic [8:0] tet_corners(input logic odd, input logic [CNT_W-1:0] t);
    logic [8:0] r;
    case ({odd, t})
      5'h00: r = {3'd0, 3'd1, 3'd4};
      5'h01: r = {3'd1, 3'd5, 3'd4};
      5'h02: r = {3'd0, 3'd2, 3'd1};
      5'h03: r = {3'd1, 3'd2, 3'd3};
      5'h04: r = {3'd0, 3'd4, 3'd6};
      5'h05: r = {3'd0, 3'd6, 3'd2};
      5'h06: r = {3'd3, 3'd2, 3'd7};
      5'h07: r = {3'd2, 3'd6, 3'd7};
      5'h08: r = {3'd4, 3'd5, 3'd7};
      5'h09: r = {3'd4, 3'd7, 3'd6};
      5'h0a: r = {3'd1, 3'd3, 3'd5};
      5'h0b: r = {3'd3, 3'd7, 3'd5};
      5'h10: r = {3'd0, 3'd1, 3'd5};
      5'h11: r = {3'd0, 3'd5, 3'd4};
      5'h12: r = {3'd0, 3'd3, 3'd1};
      5'h13: r = {3'd0, 3'd2, 3'd3};
      5'h14: r = {3'd0, 3'd4, 3'd2};
      5'h15: r = {3'd2, 3'd4, 3'd6};
      5'h16: r = {3'd3, 3'd2, 3'd6};
      5'h17: r = {3'd3, 3'd6, 3'd7};
      5'h18: r = {3'd5, 3'd7, 3'd6};
      5'h19: r = {3'd5, 3'd6, 3'd4};
      5'h1a: r = {3'd1, 3'd3, 3'd7};
      5'h1b: r = {3'd1, 3'd7, 3'd5};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/hgc_cfg.sv
// hgc_cfg: grid size registers with write port and clamping to the
// maximum cells per axis. Depends on hgc_pkg.
`default_nettype none

module hgc_cfg
  import hgc_pkg::*;
#(
  parameter int unsigned MAX_CELLS_PER_DIM = MAX_CELLS_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output grid_t                     grid_o
);

  localparam logic [CFG_W+1:0] MaxCells = (CFG_W+2)'(MAX_CELLS_PER_DIM);

  logic [CFG_W-1:0] cells_x_q, cells_y_q, cells_z_q;

  // result always fits CFG_W bits: either no clamp or clamp to a max below 128
  function automatic logic [CFG_W-1:0] clamp(input logic [CFG_W-1:0] v);
    logic [CFG_W+1:0] w;
    w = {2'b00, v};
    return (w > MaxCells) ? MaxCells[CFG_W-1:0] : v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= CFG_W'(1);
      cells_y_q <= CFG_W'(1);
      cells_z_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_CELLS_X: cells_x_q <= cfg_wdata_i;
        REG_CELLS_Y: cells_y_q <= cfg_wdata_i;
        REG_CELLS_Z: cells_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign grid_o.cx = clamp(cells_x_q);
  assign grid_o.cy = clamp(cells_y_q);
  assign grid_o.cz = clamp(cells_z_q);

endmodule

`default_nettype wire

FILE: sv/hgc_index.sv
// hgc_index: two-stage index arithmetic per cell (row products, then base,
// apex and strides). Depends on hgc_pkg.
`default_nettype none

module hgc_index
  import hgc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [COORD_W-1:0] cell_x_i,
  input  wire logic [COORD_W-1:0] cell_y_i,
  input  wire logic [COORD_W-1:0] cell_z_i,
  input  grid_t                   grid_i,
  output geom_t                   geom_o,
  output logic                    geom_valid_o,
  input  wire logic               geom_take_i
);

  logic [CFG_W:0] nx, ny, nz;

  // stage 1
  logic               s1_v_q, s1_v_d;
  logic [14:0]        s1_a_q;      // x*ny + y
  logic [13:0]        s1_b_q;      // x*cy + y
  logic [14:0]        s1_plane_q;  // ny*nz
  logic [COORD_W-1:0] s1_z_q;
  logic               s1_bad_q, s1_odd_q;

  // stage 2
  logic  s2_v_q, s2_v_d;
  geom_t s2_q, s2_d;

  logic s1_free, s2_free, in_acc;

  assign nx = {1'b0, grid_i.cx} + (CFG_W+1)'(1);
  assign ny = {1'b0, grid_i.cy} + (CFG_W+1)'(1);
  assign nz = {1'b0, grid_i.cz} + (CFG_W+1)'(1);

  assign s2_free    = !s2_v_q || geom_take_i;
  assign s1_free    = !s1_v_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;

  always_comb begin
    s1_v_d = in_acc ? 1'b1 : (s2_free ? 1'b0 : s1_v_q);
    s2_v_d = s2_free ? s1_v_q : s2_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_a_q     <= 15'(cell_x_i) * 15'(ny) + 15'(cell_y_i);
      s1_b_q     <= 14'(cell_x_i) * 14'(grid_i.cy) + 14'(cell_y_i);
      s1_plane_q <= 15'(ny) * 15'(nz);
      s1_z_q     <= cell_z_i;
      s1_bad_q   <= ({1'b0, cell_x_i} >= grid_i.cx) || ({1'b0, cell_y_i} >= grid_i.cy) ||
                    ({1'b0, cell_z_i} >= grid_i.cz);
      s1_odd_q   <= cell_x_i[0] ^ cell_y_i[0] ^ cell_z_i[0];
    end
  end

  // all sums wrap at the index width, as the result fields do
  always_comb begin
    s2_d.base  = IDX_W'(s1_a_q) * IDX_W'(nz) + IDX_W'(s1_z_q);
    s2_d.apex  = IDX_W'(nx) * IDX_W'(s1_plane_q) + IDX_W'(s1_b_q) * IDX_W'(grid_i.cz) +
                 IDX_W'(s1_z_q);
    s2_d.plane = IDX_W'(s1_plane_q);
    s2_d.nz    = nz;
    s2_d.odd   = s1_odd_q;
    s2_d.bad   = s1_bad_q;
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && s1_v_q) begin
      s2_q <= s2_d;
    end
  end

  assign geom_o       = s2_q;
  assign geom_valid_o = s2_v_q;

endmodule

`default_nettype wire

FILE: sv/hgc_emit.sv
// hgc_emit: steps through the twelve tetrahedra of a cell, or one zeroed
// result for a bad cell; drives the result register. Depends on hgc_pkg.
`default_nettype none

module hgc_emit
  import hgc_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  geom_t             geom_i,
  input  wire logic         geom_valid_i,
  output logic              geom_take_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output logic [CNT_W-1:0]  tet_number_o,
  output logic [IDX_W-1:0]  corner_a_o,
  output logic [IDX_W-1:0]  corner_b_o,
  output logic [IDX_W-1:0]  corner_c_o,
  output logic [IDX_W-1:0]  apex_index_o,
  output logic              bad_cell_o,
  output logic              last_tet_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_v_q, out_v_d;
  logic             load, last;
  logic [8:0]       sel;

  function automatic logic [IDX_W-1:0] corner_idx(input geom_t g, input logic [2:0] c);
    logic [IDX_W-1:0] r;
    r = g.base + (c[2] ? g.plane : '0) + (c[1] ? IDX_W'(g.nz) : '0) + IDX_W'(c[0]);
    return r;
  endfunction

  assign load        = geom_valid_i && (!out_v_q || !out_stall_i);
  assign last        = geom_i.bad || (cnt_q == LAST_TET);
  assign geom_take_o = load && last;
  assign sel         = tet_corners(geom_i.odd, cnt_q);

  always_comb begin
    cnt_d   = cnt_q;
    out_v_d = out_v_q;
    if (load) begin
      out_v_d = 1'b1;
      cnt_d   = last ? '0 : cnt_q + CNT_W'(1);
    end else if (!out_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (geom_i.bad) begin
        tet_number_o <= '0;
        corner_a_o   <= '0;
        corner_b_o   <= '0;
        corner_c_o   <= '0;
        apex_index_o <= '0;
        bad_cell_o   <= 1'b1;
        last_tet_o   <= 1'b1;
      end else begin
        tet_number_o <= cnt_q;
        corner_a_o   <= corner_idx(geom_i, sel[8:6]);
        corner_b_o   <= corner_idx(geom_i, sel[5:3]);
        corner_c_o   <= corner_idx(geom_i, sel[2:0]);
        apex_index_o <= geom_i.apex;
        bad_cell_o   <= 1'b0;
        last_tet_o   <= (cnt_q == LAST_TET);
      end
    end
  end

  assign out_valid_o = out_v_q;

endmodule

`default_nettype wire

FILE: sv/hex_to_tet_grid_connectivity.sv
// hex_to_tet_grid_connectivity: top level, one hexahedral grid cell in,
// its twelve tetrahedra out. Depends on hgc_pkg, hgc_cfg, hgc_index, hgc_emit.
`default_nettype none

// Channel  Direction  Handshake            Beat
// cfg      in         cfg_we_i             cfg_idx_i, cfg_wdata_i
// in       in         in_valid_i/stall_o   cell_x_i, cell_y_i, cell_z_i
// out      out        out_valid_o/stall_i  tet_number_o .. last_tet_o
//
// A cell yields its twelve tetrahedra one per cycle from the emitter's counter
// while out_stall_i is low; an out-of-grid cell yields a single result. Input
// beats pass two register stages of index arithmetic (row products, then
// base/apex) and then the emitter's result register; the next cell is taken
// while the current one is still emitting. Reset sets all cell counts to one
// and empties the pipeline. Output stall holds the result register and backs
// up through the stages to in_stall_o.

module hex_to_tet_grid_connectivity
  import hgc_pkg::*;
#(
  parameter int unsigned MAX_CELLS_PER_DIM = MAX_CELLS_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  // cell input
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [COORD_W-1:0]   cell_x_i,
  input  wire logic [COORD_W-1:0]   cell_y_i,
  input  wire logic [COORD_W-1:0]   cell_z_i,
  // tetrahedron output
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [CNT_W-1:0]          tet_number_o,
  output logic [IDX_W-1:0]          corner_a_o,
  output logic [IDX_W-1:0]          corner_b_o,
  output logic [IDX_W-1:0]          corner_c_o,
  output logic [IDX_W-1:0]          apex_index_o,
  output logic                      bad_cell_o,
  output logic                      last_tet_o
);

  grid_t grid;
  geom_t geom;
  logic  geom_valid, geom_take;

  // Grid size registers; counts above the maximum are clamped here.
  hgc_cfg #(
    .MAX_CELLS_PER_DIM (MAX_CELLS_PER_DIM)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .grid_o      (grid)
  );

  // Lattice index of corner 0, strides and centre vertex index.
  hgc_index u_index (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cell_x_i     (cell_x_i),
    .cell_y_i     (cell_y_i),
    .cell_z_i     (cell_z_i),
    .grid_i       (grid),
    .geom_o       (geom),
    .geom_valid_o (geom_valid),
    .geom_take_i  (geom_take)
  );

  // Tetrahedron sequencer: table lookup per step, corners as base + strides.
  hgc_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .geom_valid_i (geom_valid),
    .geom_take_o  (geom_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tet_number_o (tet_number_o),
    .corner_a_o   (corner_a_o),
    .corner_b_o   (corner_b_o),
    .corner_c_o   (corner_c_o),
    .apex_index_o (apex_index_o),
    .bad_cell_o   (bad_cell_o),
    .last_tet_o   (last_tet_o)
  );

endmodule

`default_nettype wire
